FILE: src/sipu_pkg.sv
// ============================================================================
// sipu_pkg
// Shared types, constants and tables of the spectral index pixel unit.
// ============================================================================
package sipu_pkg;

    // Sample and result widths.
    localparam int SAMPLE_W = 16;
    localparam int NBANDS   = 7;
    localparam int NUM_W    = 32;          // signed numerator
    localparam int DEN_W    = 24;          // signed divisor
    localparam int QUO_W    = 15;          // quotient bits below the clip limit
    localparam int ROOT_W   = 26;          // square root bits
    localparam int SREM_W   = 51;          // square root radicand bits
    localparam int ITER_N   = ROOT_W;      // iteration stages
    localparam int STEP_W   = 5;

    localparam logic signed [SAMPLE_W-1:0] NODATA_IN  = 16'sh8000;
    localparam logic signed [15:0]         NODATA_OUT = 16'sh8000;
    localparam logic signed [15:0]         MAX_VAL    = 16'sd32767;

    // Index select codes.
    typedef enum logic [3:0] {
        IDX_NBR   = 4'd0,
        IDX_NBR2  = 4'd1,
        IDX_EVI   = 4'd2,
        IDX_SAVI  = 4'd3,
        IDX_MSAVI = 4'd4,
        IDX_NDVI  = 4'd5,
        IDX_NDMI  = 4'd6,
        IDX_TCB   = 4'd7,
        IDX_TCG   = 4'd8,
        IDX_TCW   = 4'd9,
        IDX_SR    = 4'd10,
        IDX_CL    = 4'd11,
        IDX_HZ    = 4'd12
    } t_index;

    // Tasseled cap weights (x10000) for bands 1, 2, 3, 4, 5 and 7.
    localparam logic signed [14:0] TC_W [3][6] = '{
        '{ 15'sd2043,  15'sd4158,  15'sd5524, 15'sd5741,  15'sd3124,  15'sd2303},
        '{-15'sd1603, -15'sd2819, -15'sd4934, 15'sd7940, -15'sd2,    -15'sd1446},
        '{ 15'sd315,   15'sd2021,  15'sd3102, 15'sd1594, -15'sd6806, -15'sd6109}
    };

    // Bands that each index reads, band 1 in the lowest bit.
    function automatic logic [NBANDS-1:0] used_mask(input logic [3:0] sel);
        logic [NBANDS-1:0] m;
        case (sel)
            IDX_NBR:                    m = 7'h48;
            IDX_NBR2:                   m = 7'h50;
            IDX_EVI:                    m = 7'h0D;
            IDX_SAVI, IDX_MSAVI,
            IDX_NDVI, IDX_SR:           m = 7'h0C;
            IDX_NDMI:                   m = 7'h18;
            IDX_TCB, IDX_TCG, IDX_TCW:  m = 7'h5F;
            IDX_CL:                     m = 7'h21;
            IDX_HZ:                     m = 7'h05;
            default:                    m = 7'h00;
        endcase
        return m;
    endfunction

    // Work carried through the shared divide and square root stages.
    typedef struct packed {
        logic                     bad;
        logic                     divide;
        logic                     neg;
        logic                     clip;
        logic signed [17:0]       t;
        logic                     cec;
        logic [NUM_W-2:0]         rdiv;
        logic [DEN_W-2:0]         dmag;
        logic [QUO_W-1:0]         quo;
        logic [SREM_W-1:0]        srem;
        logic [ROOT_W-1:0]        root;
    } t_iter;

endpackage

FILE: src/spectral_index_pixel_unit.sv
// ============================================================================
// spectral_index_pixel_unit
// Vegetation, burn, tasseled cap and ratio indices of one pixel per beat.
// ============================================================================
// The unit takes one pixel beat per clock while s_tready is high and returns
// one index beat per pixel, in order. The pipeline depth is set by the 26-stage
// square root pipeline used for MSAVI, through which the 15-bit restoring
// divider of the other indices runs in parallel; four stages of operand set-up
// come before it and one output register after it. Each stage holds a valid bit
// and only stalls when the stage after it is full, so bubbles are squeezed out
// during a stall. The user must write index_select with i_cfg_we only while no
// pixel is in flight; the block itself does not enforce this.
module spectral_index_pixel_unit
    import sipu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata,   // index_select
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,       // band_one .. band_seven, 16 bits each
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata        // index_value[15:0], is_nodata, was_clipped
);

    localparam int NSTG = ITER_N + 5;

    logic [3:0] r_sel;
    logic [NSTG-1:0] w_vld;
    logic [NSTG-1:0] w_en;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 4'd0;
        end else if (i_cfg_we) begin
            r_sel <= i_cfg_wdata;
        end
    end

    // A stage loads when it is empty or the stage after it moves.
    always_comb begin
        w_en[NSTG-1] = !w_vld[NSTG-1] | m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !w_vld[k] | w_en[k+1];
        end
    end
    assign s_tready = w_en[0];

    // Stage 1: samples, tasseled cap products, MSAVI terms.
    logic                       r1_vld;
    logic [3:0]                 r1_sel;
    logic signed [SAMPLE_W-1:0] r1_b [NBANDS];
    logic signed [30:0]         r1_p [6];
    logic signed [17:0]         r1_t;
    logic signed [17:0]         r1_d;
    logic signed [SAMPLE_W-1:0] n1_b [NBANDS];
    logic [1:0]                 n1_row;

    always_comb begin
        for (int i = 0; i < NBANDS; i++) begin
            n1_b[i] = s_tdata[SAMPLE_W*i +: SAMPLE_W];
        end
        case (r_sel)
            IDX_TCG: n1_row = 2'd1;
            IDX_TCW: n1_row = 2'd2;
            default: n1_row = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en[0]) begin
            r1_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_sel <= r_sel;
            r1_b   <= n1_b;
            for (int i = 0; i < 5; i++) begin
                r1_p[i] <= 31'(n1_b[i]) * 31'(TC_W[n1_row][i]);
            end
            r1_p[5] <= 31'(n1_b[6]) * 31'(TC_W[n1_row][5]);
            r1_t    <= {n1_b[3][SAMPLE_W-1], n1_b[3], 1'b1};
            r1_d    <= 18'(n1_b[3]) - 18'(n1_b[2]);
        end
    end

    // Stage 2: numerator, divisor, nodata tests, square of t.
    logic                    r2_vld;
    logic                    r2_bad;
    logic                    r2_divide;
    logic                    r2_msavi;
    logic signed [NUM_W-1:0] r2_num;
    logic signed [DEN_W-1:0] r2_den;
    logic [31:0]             r2_tt;
    logic signed [17:0]      r2_t;
    logic signed [17:0]      r2_d;
    logic signed [NUM_W-1:0] n2_num;
    logic signed [31:0]      n2_den;
    logic                    n2_bad;
    logic                    n2_divide;
    logic [NBANDS-1:0]       n2_nd;
    logic [16:0]             n2_at;
    logic [33:0]             n2_sq;

    always_comb begin
        for (int i = 0; i < NBANDS; i++) begin
            n2_nd[i] = r1_b[i] == NODATA_IN;
        end
        n2_num    = '0;
        n2_den    = 32'sd1;
        n2_divide = 1'b1;
        n2_bad    = |(used_mask(r1_sel) & n2_nd);
        case (r1_sel)
            IDX_NBR: begin
                n2_num = 32'sd1000 * (32'(r1_b[3]) - 32'(r1_b[6]));
                n2_den = 32'(r1_b[3]) + 32'(r1_b[6]);
            end
            IDX_NBR2: begin
                n2_num = 32'sd1000 * (32'(r1_b[4]) - 32'(r1_b[6]));
                n2_den = 32'(r1_b[4]) + 32'(r1_b[6]);
            end
            IDX_EVI: begin
                n2_num = 32'sd5000 * (32'(r1_b[3]) - 32'(r1_b[2]));
                n2_den = 32'sd2 * 32'(r1_b[3]) + 32'sd12 * 32'(r1_b[2])
                       - 32'sd15 * 32'(r1_b[0]) + 32'sd2;
            end
            IDX_SAVI: begin
                n2_num = 32'sd3000 * (32'(r1_b[3]) - 32'(r1_b[2]));
                n2_den = 32'sd2 * 32'(r1_b[3]) + 32'sd2 * 32'(r1_b[2]) + 32'sd1;
            end
            IDX_MSAVI: begin
                n2_divide = 1'b0;
            end
            IDX_NDVI: begin
                n2_num = 32'sd1000 * (32'(r1_b[3]) - 32'(r1_b[2]));
                n2_den = 32'(r1_b[3]) + 32'(r1_b[2]);
            end
            IDX_NDMI: begin
                n2_num = 32'sd1000 * (32'(r1_b[3]) - 32'(r1_b[4]));
                n2_den = 32'(r1_b[3]) + 32'(r1_b[4]);
            end
            IDX_TCB, IDX_TCG, IDX_TCW: begin
                n2_num = 32'(r1_p[0]) + 32'(r1_p[1]) + 32'(r1_p[2])
                       + 32'(r1_p[3]) + 32'(r1_p[4]) + 32'(r1_p[5]);
                n2_den = 32'sd10000;
            end
            IDX_SR: begin
                n2_num = 32'sd1000 * 32'(r1_b[3]);
                n2_den = 32'(r1_b[2]);
            end
            IDX_CL: begin
                n2_num = 32'sd1000 * 32'(r1_b[0]);
                n2_den = 32'(r1_b[5]);
            end
            IDX_HZ: begin
                n2_num = 32'sd1000 * 32'(r1_b[0]);
                n2_den = 32'(r1_b[2]);
            end
            default: begin
                n2_bad    = 1'b1;
                n2_divide = 1'b0;
            end
        endcase
        n2_at = r1_t[17] ? 17'(-r1_t) : 17'(r1_t);
        n2_sq = n2_at * n2_at;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en[1]) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_bad    <= n2_bad;
            r2_divide <= n2_divide;
            r2_msavi  <= r1_sel == IDX_MSAVI;
            r2_num    <= n2_num;
            r2_den    <= DEN_W'(n2_den);
            r2_tt     <= n2_sq[31:0];
            r2_t      <= r1_t;
            r2_d      <= r1_d;
        end
    end

    // Stage 3: root argument, magnitudes and sign of the quotient.
    logic                    r3_vld;
    logic                    r3_bad;
    logic                    r3_divide;
    logic                    r3_neg;
    logic                    r3_dzero;
    logic [32:0]             r3_arg;
    logic [NUM_W-2:0]        r3_an;
    logic [DEN_W-2:0]        r3_ad;
    logic signed [17:0]      r3_t;
    logic                    r3_cec;
    logic signed [33:0]      n3_arg;

    assign n3_arg = $signed({2'b00, r2_tt}) - (34'(r2_d) <<< 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en[2]) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_bad    <= r2_bad | (r2_msavi & n3_arg[33]);
            r3_divide <= r2_divide;
            r3_neg    <= r2_num[NUM_W-1] ^ r2_den[DEN_W-1];
            r3_dzero  <= r2_den == '0;
            r3_arg    <= n3_arg[32:0];
            r3_an     <= r2_num[NUM_W-1] ? (NUM_W-1)'(-r2_num) : (NUM_W-1)'(r2_num);
            r3_ad     <= r2_den[DEN_W-1] ? (DEN_W-1)'(-r2_den) : (DEN_W-1)'(r2_den);
            r3_t      <= r2_t;
            r3_cec    <= !r2_t[17] && !r2_d[17];
        end
    end

    // Stage 4: radicand scaled by 500 squared; start of the iterations.
    logic  r4_vld;
    t_iter r4_d;
    logic [50:0] n4_m;

    assign n4_m = r3_arg * 18'd250000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en[3]) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_d.bad    <= r3_bad | (r3_divide & r3_dzero);
            r4_d.divide <= r3_divide;
            r4_d.neg    <= r3_neg;
            r4_d.clip   <= 1'b0;
            r4_d.t      <= r3_t;
            r4_d.cec    <= r3_cec;
            r4_d.rdiv   <= r3_an;
            r4_d.dmag   <= r3_ad;
            r4_d.quo    <= '0;
            r4_d.srem   <= n4_m;
            r4_d.root   <= '0;
        end
    end

    // Iteration stages: shared divider and square root.
    logic  w_iv [ITER_N+1];
    t_iter w_id [ITER_N+1];

    assign w_iv[0] = r4_vld;
    assign w_id[0] = r4_d;

    for (genvar j = 0; j < ITER_N; j++) begin : g_step
        sipu_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[4+j]),
            .i_idx   (STEP_W'(j)),
            .i_vld   (w_iv[j]),
            .i_d     (w_id[j]),
            .o_vld   (w_iv[j+1]),
            .o_d     (w_id[j+1])
        );
        assign w_vld[4+j] = w_iv[j+1];
    end

    assign w_vld[0] = r1_vld;
    assign w_vld[1] = r2_vld;
    assign w_vld[2] = r3_vld;
    assign w_vld[3] = r4_vld;

    // Output stage: sign, clamp and nodata.
    t_iter              w_fd;
    logic               r_fvld;
    logic signed [15:0] r_fval;
    logic               r_fnd;
    logic               r_fclip;
    logic signed [15:0] nf_val;
    logic               nf_clip;
    logic [15:0]        nf_qm;
    logic [ROOT_W:0]    nf_sub;
    logic signed [29:0] nf_res;

    assign w_fd = w_id[ITER_N];

    always_comb begin
        nf_qm  = w_fd.clip ? 16'(MAX_VAL) : {1'b0, w_fd.quo};
        nf_sub = w_fd.cec ? (ROOT_W+1)'(w_fd.root) + (ROOT_W+1)'(w_fd.srem != '0)
                          : (ROOT_W+1)'(w_fd.root);
        nf_res = 30'(w_fd.t) * 30'sd500 - $signed({3'b000, nf_sub});
        if (w_fd.bad) begin
            nf_val  = NODATA_OUT;
            nf_clip = 1'b0;
        end else if (w_fd.divide) begin
            nf_val  = w_fd.neg ? -$signed(nf_qm) : $signed(nf_qm);
            nf_clip = w_fd.clip;
        end else if (nf_res > 30'sd32767) begin
            nf_val  = MAX_VAL;
            nf_clip = 1'b1;
        end else if (nf_res < -30'sd32767) begin
            nf_val  = -MAX_VAL;
            nf_clip = 1'b1;
        end else begin
            nf_val  = 16'(nf_res);
            nf_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= 1'b0;
        end else if (w_en[NSTG-1]) begin
            r_fvld <= w_iv[ITER_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            r_fval  <= nf_val;
            r_fnd   <= w_fd.bad;
            r_fclip <= nf_clip;
        end
    end

    assign w_vld[NSTG-1] = r_fvld;
    assign m_tvalid      = r_fvld;
    assign m_tdata       = {6'b0, r_fclip, r_fnd, r_fval};

    // A nodata beat is never flagged as clipped.
    a_nd_noclip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(r_fnd && r_fclip))
        else $error("nodata beat flagged as clipped");

    // The nodata code appears exactly on nodata beats.
    a_nd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((r_fval == NODATA_OUT) == r_fnd))
        else $error("nodata code and flag disagree");

    // With an empty output register the input side is always open.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A waiting result is held until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting result changed");

endmodule

FILE: src/sipu_step.sv
// ============================================================================
// sipu_step
// One iteration stage: one square root bit and, where i_idx allows, one quotient bit or the clip test.
// ============================================================================
module sipu_step
    import sipu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [STEP_W-1:0] i_idx,
    input  logic              i_vld,
    input  t_iter             i_d,
    output logic              o_vld,
    output t_iter             o_d
);

    logic              r_vld;
    t_iter             r_d;
    t_iter             n_d;
    logic [5:0]        sb;
    logic [SREM_W:0]   trial;
    logic [3:0]        kk;
    logic [NUM_W+QUO_W-2:0] dsh;
    logic [NUM_W+QUO_W-2:0] rext;

    // Square root bit and divide step of this stage.
    always_comb begin
        n_d   = i_d;
        sb    = 6'(ROOT_W - 1) - {1'b0, i_idx};
        trial = ((SREM_W+1)'(i_d.root) << (sb + 6'd1))
              + ((SREM_W+1)'(1) << {sb, 1'b0});
        if ({1'b0, i_d.srem} >= trial) begin
            n_d.srem = i_d.srem - trial[SREM_W-1:0];
            n_d.root = i_d.root | (ROOT_W'(1) << sb);
        end
        kk   = 4'(QUO_W) - i_idx[3:0];
        rext = (NUM_W+QUO_W-1)'(i_d.rdiv);
        dsh  = (NUM_W+QUO_W-1)'(i_d.dmag) << kk;
        if (i_idx == '0) begin
            // Quotient of 32768 or more clips.
            n_d.clip = rext >= {i_d.dmag, QUO_W'(0)};
        end else if (i_idx <= STEP_W'(QUO_W)) begin
            if (rext >= dsh) begin
                n_d.rdiv = i_d.rdiv - dsh[NUM_W-2:0];
                n_d.quo  = i_d.quo | (QUO_W'(1) << kk);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule
